// ===== rtl/core/ssba_pkg.sv =====
// Package for the swap slot bitmap allocator.
// Holds sizes, status and action codes and the controller state type.
// No dependencies.
package ssba_pkg;

  localparam int WORD_BITS       = 16;
  localparam int WORD_SHIFT      = 4;
  localparam int DEF_MAX_SECTORS = 1024;
  localparam int DEF_RUN_LENGTH  = 8;
  localparam int DEV_W           = 11;
  localparam int ACTION_W        = 2;
  localparam int SECTOR_W        = 10;
  localparam int STATUS_W        = 2;

  localparam logic [DEV_W-1:0] DEV_RESET = 11'd1024;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RECLAIM = 2'd1,
    ACT_FREE    = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOT_USED = 2'd2,
    STATUS_RANGE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CHK_RD,
    ST_CHK_EVAL,
    ST_SET_RD,
    ST_SET_WR,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/core/ssba_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// Depends on nothing.
module ssba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/swap_slot_bitmap_allocator_top.sv =====
// Swap slot bitmap allocator: used-bit bitmap held in a word-wide RAM.
// Depends on ssba_pkg and ssba_ram.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request beat: in_action
//   (allocate, reclaim, free) and in_start_sector. Result channel
//   (out_valid/out_stall) returns one beat per request: out_status and
//   out_found_sector. cfg_we/cfg_wdata set the device size in sectors.
//   One request is in flight at a time; in_stall is high while it is worked.
//   Allocate streams the bitmap one 16-sector word per cycle from sector 0.
//   A hit then marks each word the run touches by a read and a write of it;
//   a full device answers once the scan has passed the last word.
//   Reclaim reads and checks each word the run spans, then on success clears
//   them with a read and a write per word; free clears them without the check.
//   Out-of-range or unknown requests answer without touching the RAM.
//   Reset clears the bitmap one word per cycle, with in_stall held high; the
//   device size resets to 1024.
//   The result sits in an output register; a stalled receiver holds it, and
//   the next request is accepted meanwhile but waits to post its result.
module swap_slot_bitmap_allocator_top #(
  parameter int MAX_SECTORS = ssba_pkg::DEF_MAX_SECTORS,
  parameter int RUN_LENGTH  = ssba_pkg::DEF_RUN_LENGTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ssba_pkg::ACTION_W-1:0]     in_action,
  input  logic [ssba_pkg::SECTOR_W-1:0]     in_start_sector,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssba_pkg::STATUS_W-1:0]     out_status,
  output logic [ssba_pkg::SECTOR_W-1:0]     out_found_sector,
  input  logic                              cfg_we,
  input  logic [ssba_pkg::DEV_W-1:0]        cfg_wdata
);

  localparam int WB    = ssba_pkg::WORD_BITS;
  localparam int WS    = ssba_pkg::WORD_SHIFT;
  localparam int DEPTH = (MAX_SECTORS + WB - 1) / WB;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SWA   = $clog2(MAX_SECTORS + WB + RUN_LENGTH) + 1;
  localparam int SW    = (SWA > 12) ? SWA : 12;
  localparam int WCW   = SW - WS;
  localparam int CARW  = $clog2(RUN_LENGTH + WB + 1);

  ssba_pkg::state_t state_r, state_nxt;

  logic [ssba_pkg::DEV_W-1:0]    dev_r;
  logic [SW-1:0]                 start_r, start_nxt;
  logic [WCW-1:0]                wcnt_r, wcnt_nxt;
  logic [WCW-1:0]                dw_r, dw_nxt;
  logic                          pend_r, pend_nxt;
  logic [CARW-1:0]               carry_r, carry_nxt;
  logic                          set_r, set_nxt;
  ssba_pkg::status_t             status_r, status_nxt;
  logic [ssba_pkg::SECTOR_W-1:0] found_r, found_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ssba_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ssba_pkg::SECTOR_W-1:0] out_found_r, out_found_nxt;

  logic          ram_we;
  logic [WB-1:0] ram_wdata;
  logic [WB-1:0] ram_rdata;

  logic [SW-1:0] size;
  logic [SW-1:0] in_start;
  logic          in_range_ok;
  logic          accept;
  logic          out_free;

  // scan datapath
  logic [SW-1:0]   scan_base;
  logic [SW-1:0]   data_base;
  logic            issue;
  logic            last_word;
  logic [WB-1:0]   free_v;
  logic [WB-1:0]   pre_v;
  logic [WB-1:0]   top_v;
  logic [WB-1:0]   end_ok;
  logic            hit;
  logic [WS-1:0]   hit_idx;
  logic [SW-1:0]   hit_sector;
  logic [WS:0]     lead;
  logic [CARW-1:0] carry_sum;
  logic [CARW-1:0] carry_upd;

  // run sweep datapath
  logic [SW-1:0]  run_end;
  logic [WCW-1:0] end_word;
  logic [SW-1:0]  word_base;
  logic [WB-1:0]  run_mask;
  logic           at_end;
  logic           run_used;

  ssba_ram #(
    .WIDTH (WB),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wcnt_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (wcnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign size = (SW'(dev_r) > SW'(MAX_SECTORS)) ? SW'(MAX_SECTORS) : SW'(dev_r);
  assign in_start    = SW'(in_start_sector);
  assign in_range_ok = (in_start + SW'(RUN_LENGTH)) <= size;
  assign in_stall    = (state_r != ssba_pkg::ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;

  assign scan_base = {wcnt_r, WS'(0)};
  assign data_base = {dw_r, WS'(0)};
  assign issue     = scan_base < size;
  assign last_word = (data_base + SW'(WB)) >= size;

  always_comb begin
    logic w;
    for (int j = 0; j < WB; j++) begin
      free_v[j] = !ram_rdata[j] && ((data_base + SW'(j)) < size);
    end
    for (int j = 0; j < WB; j++) begin
      pre_v[j] = 1'b1;
      top_v[j] = 1'b1;
      w        = 1'b1;
      for (int k = 0; k < WB; k++) begin
        if (k <= j) pre_v[j] = pre_v[j] & free_v[k];
        if (k >= j) top_v[j] = top_v[j] & free_v[k];
        if ((k <= j) && (k + RUN_LENGTH > j)) w = w & free_v[k];
      end
      if (j + 1 >= RUN_LENGTH) begin
        end_ok[j] = w;
      end else begin
        end_ok[j] = pre_v[j] && (int'(carry_r) + j + 1 >= RUN_LENGTH);
      end
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (end_ok[j]) begin
        hit     = 1'b1;
        hit_idx = WS'(j);
      end
    end
  end

  assign hit_sector = data_base + SW'(hit_idx) + SW'(1) - SW'(RUN_LENGTH);

  always_comb begin
    lead = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (top_v[j]) lead = (WS + 1)'(WB - j);
    end
  end

  assign carry_sum = (CARW'(lead) == CARW'(WB)) ? (carry_r + CARW'(WB)) : CARW'(lead);
  assign carry_upd = (carry_sum > CARW'(RUN_LENGTH)) ? CARW'(RUN_LENGTH) : carry_sum;

  assign run_end   = start_r + SW'(RUN_LENGTH) - SW'(1);
  assign end_word  = run_end[SW-1:WS];
  assign word_base = {wcnt_r, WS'(0)};
  assign at_end    = (wcnt_r == end_word);

  always_comb begin
    for (int j = 0; j < WB; j++) begin
      run_mask[j] = ((word_base + SW'(j)) >= start_r) && ((word_base + SW'(j)) <= run_end);
    end
  end

  assign run_used = ((ram_rdata & run_mask) == run_mask);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssba_pkg::ST_CLEAR: begin
        if (wcnt_r == WCW'(DEPTH - 1)) state_nxt = ssba_pkg::ST_IDLE;
      end
      ssba_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ssba_pkg::ACT_ALLOC: begin
              state_nxt = (size < SW'(RUN_LENGTH)) ? ssba_pkg::ST_RESP : ssba_pkg::ST_SCAN;
            end
            ssba_pkg::ACT_RECLAIM: begin
              state_nxt = in_range_ok ? ssba_pkg::ST_CHK_RD : ssba_pkg::ST_RESP;
            end
            ssba_pkg::ACT_FREE: begin
              state_nxt = in_range_ok ? ssba_pkg::ST_SET_RD : ssba_pkg::ST_RESP;
            end
            default: state_nxt = ssba_pkg::ST_RESP;
          endcase
        end
      end
      ssba_pkg::ST_SCAN: begin
        if (pend_r && hit) begin
          state_nxt = ssba_pkg::ST_SET_RD;
        end else if (pend_r && last_word) begin
          state_nxt = ssba_pkg::ST_RESP;
        end
      end
      ssba_pkg::ST_CHK_RD:  state_nxt = ssba_pkg::ST_CHK_EVAL;
      ssba_pkg::ST_CHK_EVAL: begin
        priority if (!run_used) state_nxt = ssba_pkg::ST_RESP;
        else if (at_end)        state_nxt = ssba_pkg::ST_SET_RD;
        else                    state_nxt = ssba_pkg::ST_CHK_RD;
      end
      ssba_pkg::ST_SET_RD:  state_nxt = ssba_pkg::ST_SET_WR;
      ssba_pkg::ST_SET_WR: begin
        state_nxt = at_end ? ssba_pkg::ST_RESP : ssba_pkg::ST_SET_RD;
      end
      ssba_pkg::ST_RESP: begin
        if (out_free) state_nxt = ssba_pkg::ST_IDLE;
      end
      default: state_nxt = ssba_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    start_nxt  = start_r;
    wcnt_nxt   = wcnt_r;
    dw_nxt     = dw_r;
    pend_nxt   = 1'b0;
    carry_nxt  = carry_r;
    set_nxt    = set_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    unique case (state_r)
      ssba_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        wcnt_nxt = (wcnt_r == WCW'(DEPTH - 1)) ? '0 : wcnt_r + WCW'(1);
      end
      ssba_pkg::ST_IDLE: begin
        if (accept) begin
          start_nxt  = in_start;
          found_nxt  = '0;
          carry_nxt  = '0;
          status_nxt = ssba_pkg::STATUS_RANGE;
          unique case (in_action)
            ssba_pkg::ACT_ALLOC: begin
              status_nxt = ssba_pkg::STATUS_FULL;
              wcnt_nxt   = '0;
            end
            ssba_pkg::ACT_RECLAIM: begin
              wcnt_nxt = in_start[SW-1:WS];
            end
            ssba_pkg::ACT_FREE: begin
              wcnt_nxt = in_start[SW-1:WS];
              set_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ssba_pkg::ST_SCAN: begin
        pend_nxt = issue;
        dw_nxt   = wcnt_r;
        if (issue) wcnt_nxt = wcnt_r + WCW'(1);
        if (pend_r) begin
          if (hit) begin
            start_nxt = hit_sector;
            found_nxt = hit_sector[ssba_pkg::SECTOR_W-1:0];
            wcnt_nxt  = hit_sector[SW-1:WS];
            set_nxt   = 1'b1;
          end else begin
            carry_nxt = carry_upd;
          end
        end
      end
      ssba_pkg::ST_CHK_RD: ;
      ssba_pkg::ST_CHK_EVAL: begin
        priority if (!run_used) begin
          status_nxt = ssba_pkg::STATUS_NOT_USED;
        end else if (at_end) begin
          wcnt_nxt = start_r[SW-1:WS];
          set_nxt  = 1'b0;
        end else begin
          wcnt_nxt = wcnt_r + WCW'(1);
        end
      end
      ssba_pkg::ST_SET_RD: ;
      ssba_pkg::ST_SET_WR: begin
        ram_we    = 1'b1;
        ram_wdata = set_r ? (ram_rdata | run_mask) : (ram_rdata & ~run_mask);
        if (at_end) status_nxt = ssba_pkg::STATUS_OK;
        else        wcnt_nxt   = wcnt_r + WCW'(1);
      end
      ssba_pkg::ST_RESP: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    if ((state_r == ssba_pkg::ST_RESP) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_found_nxt  = found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssba_pkg::ST_CLEAR;
      wcnt_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      dev_r       <= ssba_pkg::DEV_RESET;
    end else begin
      state_r     <= state_nxt;
      wcnt_r      <= wcnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) dev_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    dw_r         <= dw_nxt;
    carry_r      <= carry_nxt;
    set_r        <= set_nxt;
    status_r     <= status_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_sector = out_found_r;

endmodule

// ===== dv/swap_slot_bitmap_allocator_top_tb.sv =====
// Testbench for swap_slot_bitmap_allocator_top: directed and random allocate/reclaim/free
// traffic, checked beat by beat against a bitmap predictor held in the bench.
// Depends on ssba_pkg and the allocator RTL.
module swap_slot_bitmap_allocator_top_tb;

  localparam int MAX_SECT  = ssba_pkg::DEF_MAX_SECTORS;
  localparam int RUN_LEN   = ssba_pkg::DEF_RUN_LENGTH;
  localparam int LONG_HOLD = 150;
  localparam logic [ssba_pkg::ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    ssba_pkg::status_t             status;
    logic [ssba_pkg::SECTOR_W-1:0] found;
  } slot_result_t;

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          in_valid        = 1'b0;
  logic                          in_stall;
  logic [ssba_pkg::ACTION_W-1:0] in_action       = '0;
  logic [ssba_pkg::SECTOR_W-1:0] in_start_sector = '0;
  logic                          out_valid;
  logic                          out_stall       = 1'b0;
  logic [ssba_pkg::STATUS_W-1:0] out_status;
  logic [ssba_pkg::SECTOR_W-1:0] out_found_sector;
  logic                          cfg_we          = 1'b0;
  logic [ssba_pkg::DEV_W-1:0]    cfg_wdata       = '0;

  bit   [MAX_SECT-1:0]           sect_busy;
  logic [ssba_pkg::DEV_W-1:0]    dev_size;
  slot_result_t                  expected_q[$];
  logic [ssba_pkg::SECTOR_W-1:0] live_runs[$];
  int                            err_count      = 0;
  bit                            idle_on        = 1'b1;
  int                            hold_req_count = 0;
  int                            hold_ack_count = 0;
  int                            hold_left      = 0;
  int                            burst_left     = 0;

  swap_slot_bitmap_allocator_top #(
    .MAX_SECTORS(MAX_SECT),
    .RUN_LENGTH (RUN_LEN)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_start_sector (in_start_sector),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_sector(out_found_sector),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver back-pressure: random bursts plus an on-demand long hold
  always @(posedge clk) begin
    if (hold_req_count != hold_ack_count) begin
      hold_ack_count <= hold_req_count;
      hold_left      <= LONG_HOLD - 1;
      out_stall      <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      burst_left <= $urandom_range(0, 10);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    slot_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing pending: status %0d found_sector %0d",
               out_status, out_found_sector);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          err_count++;
        end
        if (out_found_sector !== want.found) begin
          $error("found_sector: expected %0d, actual %0d", want.found, out_found_sector);
          err_count++;
        end
      end
    end
  end

  function automatic slot_result_t predict_request(
      input logic [ssba_pkg::ACTION_W-1:0] act,
      input logic [ssba_pkg::SECTOR_W-1:0] start);
    slot_result_t r;
    int unsigned  eff;
    int unsigned  run_free;
    bit           all_used;
    r.status = ssba_pkg::STATUS_RANGE;
    r.found  = '0;
    eff      = (dev_size > MAX_SECT) ? MAX_SECT : dev_size;
    case (act)
      ssba_pkg::ACT_ALLOC: begin
        r.status = ssba_pkg::STATUS_FULL;
        run_free = 0;
        for (int unsigned i = 0; i < eff; i++) begin
          run_free = sect_busy[i] ? 0 : run_free + 1;
          if (run_free == RUN_LEN) begin
            r.found  = ssba_pkg::SECTOR_W'(i + 1 - RUN_LEN);
            r.status = ssba_pkg::STATUS_OK;
            for (int k = 0; k < RUN_LEN; k++) sect_busy[i + 1 - RUN_LEN + k] = 1'b1;
            break;
          end
        end
      end
      ssba_pkg::ACT_RECLAIM: begin
        if (start + RUN_LEN <= eff) begin
          all_used = 1'b1;
          for (int k = 0; k < RUN_LEN; k++) if (!sect_busy[start + k]) all_used = 1'b0;
          if (all_used) begin
            for (int k = 0; k < RUN_LEN; k++) sect_busy[start + k] = 1'b0;
            r.status = ssba_pkg::STATUS_OK;
          end else begin
            r.status = ssba_pkg::STATUS_NOT_USED;
          end
        end
      end
      ssba_pkg::ACT_FREE: begin
        if (start + RUN_LEN <= eff) begin
          for (int k = 0; k < RUN_LEN; k++) sect_busy[start + k] = 1'b0;
          r.status = ssba_pkg::STATUS_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(input logic [ssba_pkg::ACTION_W-1:0] act,
                              input logic [ssba_pkg::SECTOR_W-1:0] start);
    slot_result_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_start_sector <= start;
    do @(posedge clk); while (in_stall);
    want = predict_request(act, start);
    expected_q.push_back(want);
    if (act == ssba_pkg::ACT_ALLOC && want.status == ssba_pkg::STATUS_OK) begin
      live_runs.push_back(want.found);
    end
  endtask

  // wait until every beat is back and the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dev_size(input logic [ssba_pkg::DEV_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    dev_size = v;
    @(posedge clk);
  endtask

  task automatic reset_block();
    sect_busy = '0;
    dev_size  = ssba_pkg::DEV_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic random_mix(input int n_items, input int max_start);
    int                            pick;
    int                            slot;
    logic [ssba_pkg::SECTOR_W-1:0] s;
    for (int j = 0; j < n_items; j++) begin
      pick = $urandom_range(0, 99);
      s    = ssba_pkg::SECTOR_W'($urandom_range(0, max_start));
      if (pick < 45) begin
        send_request(ssba_pkg::ACT_ALLOC, ssba_pkg::SECTOR_W'($urandom));
      end else if (pick < 80 && live_runs.size() > 0) begin
        slot = $urandom_range(0, live_runs.size() - 1);
        s    = live_runs[slot];
        live_runs.delete(slot);
        send_request((pick < 62) ? ssba_pkg::ACT_RECLAIM : ssba_pkg::ACT_FREE, s);
      end else if (pick < 90) begin
        send_request(ssba_pkg::ACT_RECLAIM, s);
      end else if (pick < 96) begin
        send_request(ssba_pkg::ACT_FREE, s);
      end else begin
        send_request(ACT_UNKNOWN, s);
      end
    end
  endtask

  // lowest fit, reclaim of used and partly used runs, unaligned allocation
  task automatic test_basic_ops();
    send_request(ssba_pkg::ACT_ALLOC, '0);
    send_request(ssba_pkg::ACT_ALLOC, '1);
    send_request(ssba_pkg::ACT_RECLAIM, 10'd0);
    send_request(ssba_pkg::ACT_RECLAIM, 10'd0);
    send_request(ssba_pkg::ACT_ALLOC, '0);
    send_request(ssba_pkg::ACT_FREE, 10'd12);
    send_request(ssba_pkg::ACT_RECLAIM, 10'd8);
    send_request(ssba_pkg::ACT_ALLOC, '0);
  endtask

  task automatic test_range_edges();
    send_request(ssba_pkg::ACT_FREE, 10'd1016);
    send_request(ssba_pkg::ACT_FREE, 10'd1017);
    send_request(ssba_pkg::ACT_RECLAIM, 10'd1023);
    send_request(ACT_UNKNOWN, 10'd1023);
    send_request(ACT_UNKNOWN, 10'd0);
    send_request(ssba_pkg::ACT_RECLAIM, 10'h155);
    send_request(ssba_pkg::ACT_FREE, 10'h2AA);
  endtask

  // empty device, device below one run, device of exactly one run
  task automatic test_tiny_device();
    drain();
    write_dev_size(11'd0);
    send_request(ssba_pkg::ACT_ALLOC, '0);
    send_request(ssba_pkg::ACT_FREE, 10'd0);
    drain();
    write_dev_size(11'd7);
    send_request(ssba_pkg::ACT_ALLOC, '1);
    drain();
    write_dev_size(11'd8);
    send_request(ssba_pkg::ACT_FREE, 10'd0);
    send_request(ssba_pkg::ACT_ALLOC, '0);
    send_request(ssba_pkg::ACT_ALLOC, '0);
    send_request(ssba_pkg::ACT_RECLAIM, 10'd1);
  endtask

  // sizes above the bitmap depth saturate
  task automatic test_oversize_device();
    drain();
    write_dev_size(11'd2047);
    send_request(ssba_pkg::ACT_ALLOC, '0);
    send_request(ssba_pkg::ACT_FREE, 10'd1016);
    send_request(ssba_pkg::ACT_RECLAIM, 10'd1016);
    drain();
    write_dev_size(11'd1025);
    send_request(ssba_pkg::ACT_FREE, 10'd1017);
    send_request(ssba_pkg::ACT_RECLAIM, 10'd1016);
  endtask

  // used bits beyond a shrunken size survive until it grows back
  task automatic test_shrink_grow();
    drain();
    write_dev_size(11'd16);
    send_request(ssba_pkg::ACT_ALLOC, '0);
    send_request(ssba_pkg::ACT_FREE, 10'd8);
    send_request(ssba_pkg::ACT_RECLAIM, 10'd12);
    drain();
    write_dev_size(11'd1024);
    send_request(ssba_pkg::ACT_RECLAIM, 10'd12);
    send_request(ssba_pkg::ACT_ALLOC, '0);
  endtask

  // long receiver hold while allocations run the device full
  task automatic test_fill_pressure();
    drain();
    write_dev_size(11'd96);
    hold_req_count++;
    for (int j = 0; j < 14; j++) send_request(ssba_pkg::ACT_ALLOC, '0);
    drain();
    for (int j = 0; j < 96; j += RUN_LEN) begin
      send_request(ssba_pkg::ACT_FREE, ssba_pkg::SECTOR_W'(j));
    end
  endtask

  task automatic test_random_traffic();
    int size;
    drain();
    write_dev_size(11'd1024);
    random_mix(480, 1023);
    drain();
    write_dev_size(11'd2047);
    random_mix(120, 1023);
    drain();
    size = $urandom_range(9, 200);
    write_dev_size(ssba_pkg::DEV_W'(size));
    random_mix(150, size);
  endtask

  task automatic test_quiet_tail();
    idle_on = 1'b0;
    drain();
    write_dev_size(11'd1024);
    random_mix(240, 1023);
  endtask

  initial begin
    reset_block();
    test_basic_ops();
    test_range_edges();
    test_tiny_device();
    test_oversize_device();
    test_shrink_grow();
    test_fill_pressure();
    test_random_traffic();
    test_quiet_tail();
    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== swap_slot_bitmap_allocator_top.f =====
rtl/core/ssba_pkg.sv
rtl/core/ssba_ram.sv
rtl/core/swap_slot_bitmap_allocator_top.sv
dv/swap_slot_bitmap_allocator_top_tb.sv
